// File: rtl/dspf_pkg.sv
// Shared types, constants and a helper function for the dual sensor polynomial fusion core.
package dspf_pkg;

  localparam int ADC_BITS    = 10;
  localparam int POLY_DEGREE = 4;
  localparam int SAMPLE_W    = 10;
  localparam int COEF_W      = 32;
  localparam int IDX_W       = 3;
  localparam int SRC_W       = 2;
  localparam int FRAC_W      = 16;
  localparam int X_W         = SAMPLE_W + FRAC_W - ADC_BITS;
  localparam int NUM_STG     = POLY_DEGREE + 1;
  localparam int PROD_W      = 2 * COEF_W + 1;
  localparam int TERM_W      = PROD_W - FRAC_W;
  localparam int SUM_W       = TERM_W + 1;

  localparam logic signed [COEF_W-1:0] S32_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] S32_MIN      = 32'sh8000_0000;
  localparam logic signed [COEF_W-1:0] RIGHT_NEAR_Q = 32'sd2621440;
  localparam logic signed [COEF_W-1:0] LEFT_FAR_Q   = 32'sd4259840;

  typedef enum logic {
    MODE_FUSE  = 1'b0,
    MODE_WRITE = 1'b1
  } dspf_mode_t;

  typedef enum logic {
    SIDE_LEFT  = 1'b0,
    SIDE_RIGHT = 1'b1
  } dspf_side_t;

  typedef enum logic [SRC_W-1:0] {
    SRC_RIGHT = 2'd0,
    SRC_LEFT  = 2'd1,
    SRC_AVG   = 2'd2
  } dspf_src_t;

  typedef struct packed {
    logic                     mode;
    logic [SAMPLE_W-1:0]      left_sample;
    logic [SAMPLE_W-1:0]      right_sample;
    logic                     coef_side;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } dspf_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] distance;
    logic [SRC_W-1:0]         source;
  } dspf_out_t;

  typedef struct packed {
    logic [POLY_DEGREE:0]             ld;
    logic [POLY_DEGREE:0]             wr;
    logic [POLY_DEGREE:0][COEF_W-1:0] wr_value;
  } dspf_lane_ctrl_t;

  function automatic logic signed [COEF_W-1:0] sat_sum(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-COEF_W:0] hi;
    hi = s[SUM_W-1:COEF_W-1];
    if ((&hi) || !(|hi)) begin
      return $signed(s[COEF_W-1:0]);
    end else if (s[SUM_W-1]) begin
      return S32_MIN;
    end else begin
      return S32_MAX;
    end
  endfunction

endpackage

// File: rtl/dspf_lane.sv
// One sensor lane: coefficient bank and pipelined power and term accumulation.
module dspf_lane (
  input  logic                                    clk,
  input  dspf_pkg::dspf_lane_ctrl_t               ctrl,
  input  logic [dspf_pkg::SAMPLE_W-1:0]           sample,
  output logic signed [dspf_pkg::COEF_W-1:0]      result
);

  logic signed [dspf_pkg::COEF_W-1:0] coef_r [0:dspf_pkg::POLY_DEGREE];
  logic [dspf_pkg::X_W-1:0]           x_r    [1:dspf_pkg::POLY_DEGREE];
  logic [dspf_pkg::COEF_W-1:0]        pw_r   [1:dspf_pkg::POLY_DEGREE];
  logic signed [dspf_pkg::COEF_W-1:0] acc_r  [1:dspf_pkg::NUM_STG];
  logic signed [dspf_pkg::TERM_W-1:0] term_r [1:dspf_pkg::NUM_STG];
  logic [dspf_pkg::X_W-1:0]           x_in;

  assign x_in = dspf_pkg::X_W'({sample, dspf_pkg::FRAC_W'(0)} >> dspf_pkg::ADC_BITS);

  for (genvar k = 0; k <= dspf_pkg::POLY_DEGREE; k++) begin : g_coef
    always_ff @(posedge clk) begin
      if (ctrl.wr[k]) begin
        coef_r[k] <= $signed(ctrl.wr_value[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) begin
      x_r[1]    <= x_in;
      pw_r[1]   <= dspf_pkg::COEF_W'(x_in);
      acc_r[1]  <= coef_r[0];
      term_r[1] <= '0;
    end
  end

  for (genvar k = 1; k <= dspf_pkg::POLY_DEGREE; k++) begin : g_stage
    logic signed [dspf_pkg::PROD_W-1:0] tp;
    logic signed [dspf_pkg::TERM_W-1:0] term_nxt;
    logic signed [dspf_pkg::COEF_W-1:0] acc_nxt;

    assign tp       = coef_r[k] * $signed({1'b0, pw_r[k]});
    assign term_nxt = tp[dspf_pkg::PROD_W-1:dspf_pkg::FRAC_W];
    assign acc_nxt  = dspf_pkg::sat_sum(dspf_pkg::SUM_W'(acc_r[k]) +
                                        dspf_pkg::SUM_W'(term_r[k]));

    always_ff @(posedge clk) begin
      if (ctrl.ld[k]) begin
        acc_r[k+1]  <= acc_nxt;
        term_r[k+1] <= term_nxt;
      end
    end

    if (k < dspf_pkg::POLY_DEGREE) begin : g_pow
      logic [dspf_pkg::COEF_W+dspf_pkg::X_W-1:0] m;
      logic [63:0]                               sh;
      logic [dspf_pkg::COEF_W-1:0]               pw_nxt;

      assign m      = pw_r[k] * x_r[k];
      assign sh     = 64'(m >> dspf_pkg::FRAC_W);
      assign pw_nxt = (sh > 64'hFFFF_FFFF) ? '1 : sh[dspf_pkg::COEF_W-1:0];

      always_ff @(posedge clk) begin
        if (ctrl.ld[k]) begin
          x_r[k+1]  <= x_r[k];
          pw_r[k+1] <= pw_nxt;
        end
      end
    end
  end

  assign result = dspf_pkg::sat_sum(dspf_pkg::SUM_W'(acc_r[dspf_pkg::NUM_STG]) +
                                    dspf_pkg::SUM_W'(term_r[dspf_pkg::NUM_STG]));

endmodule

// File: rtl/dspf_merge.sv
// Merge stage: selects or averages the two lane distances into the output register.
module dspf_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  logic signed [dspf_pkg::COEF_W-1:0] left,
  input  logic signed [dspf_pkg::COEF_W-1:0] right,
  input  logic                               out_stall,
  output logic                               out_valid,
  output dspf_pkg::dspf_out_t                out_item
);

  logic                           out_valid_r, out_valid_nxt;
  dspf_pkg::dspf_out_t            item_r, item_nxt;
  logic signed [dspf_pkg::COEF_W:0] pair_sum;

  assign pair_sum = (dspf_pkg::COEF_W+1)'(left) + (dspf_pkg::COEF_W+1)'(right);

  always_comb begin
    if (right < dspf_pkg::RIGHT_NEAR_Q) begin
      item_nxt.distance = right;
      item_nxt.source   = dspf_pkg::SRC_RIGHT;
    end else if (left > dspf_pkg::LEFT_FAR_Q) begin
      item_nxt.distance = left;
      item_nxt.source   = dspf_pkg::SRC_LEFT;
    end else begin
      item_nxt.distance = pair_sum[dspf_pkg::COEF_W:1];
      item_nxt.source   = dspf_pkg::SRC_AVG;
    end
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = item_r;

endmodule

// File: rtl/dual_sensor_poly_fusion_core.sv
// Top level of the dual sensor polynomial fusion core: pipeline control, two lanes, merge.
// A sample pair is registered in each lane stage in turn and then in the merge register;
//   each lane stage and the output register hold one item.
// Throughput: one item per cycle while out_stall does not hold the pipeline.
// Coefficient writes travel the pipeline in item order and give no result.
// Reset clears the stage valid bits and the output valid; coefficients are not reset.
module dual_sensor_poly_fusion_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dspf_pkg::dspf_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dspf_pkg::dspf_out_t out_item
);

  logic [dspf_pkg::NUM_STG:1] v_r, v_nxt;
  logic [dspf_pkg::NUM_STG:0] adv;
  logic [dspf_pkg::NUM_STG:1] room;
  logic                       out_room;

  logic                               mode_r  [1:dspf_pkg::NUM_STG];
  logic                               side_r  [1:dspf_pkg::POLY_DEGREE];
  logic [dspf_pkg::IDX_W-1:0]         idx_r   [1:dspf_pkg::POLY_DEGREE];
  logic signed [dspf_pkg::COEF_W-1:0] value_r [1:dspf_pkg::POLY_DEGREE];

  dspf_pkg::dspf_lane_ctrl_t          ctrl_l, ctrl_r;
  logic signed [dspf_pkg::COEF_W-1:0] dist_l, dist_r;
  logic                               merge_load;

  always_comb begin
    out_room = !out_valid || !out_stall;
    adv[dspf_pkg::NUM_STG] = v_r[dspf_pkg::NUM_STG] &&
                             (mode_r[dspf_pkg::NUM_STG] == dspf_pkg::MODE_WRITE || out_room);
    room[dspf_pkg::NUM_STG] = !v_r[dspf_pkg::NUM_STG] || adv[dspf_pkg::NUM_STG];
    for (int k = dspf_pkg::NUM_STG - 1; k >= 1; k--) begin
      adv[k]  = v_r[k] && room[k+1];
      room[k] = !v_r[k] || adv[k];
    end
    adv[0]   = in_valid && room[1];
    in_stall = !room[1];
  end

  always_comb begin
    for (int k = 1; k <= dspf_pkg::NUM_STG; k++) begin
      v_nxt[k] = adv[k-1] || (v_r[k] && !adv[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mode_r[1] <= in_item.mode;
    end
  end

  for (genvar k = 2; k <= dspf_pkg::NUM_STG; k++) begin : g_mode
    always_ff @(posedge clk) begin
      if (adv[k-1]) begin
        mode_r[k] <= mode_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side_r[1]  <= in_item.coef_side;
      idx_r[1]   <= in_item.coef_index;
      value_r[1] <= in_item.coef_value;
    end
  end

  for (genvar k = 2; k <= dspf_pkg::POLY_DEGREE; k++) begin : g_meta
    always_ff @(posedge clk) begin
      if (adv[k-1]) begin
        side_r[k]  <= side_r[k-1];
        idx_r[k]   <= idx_r[k-1];
        value_r[k] <= value_r[k-1];
      end
    end
  end

  assign ctrl_l.ld = adv[dspf_pkg::POLY_DEGREE:0];
  assign ctrl_r.ld = adv[dspf_pkg::POLY_DEGREE:0];

  assign ctrl_l.wr[0] = adv[0] && in_item.mode == dspf_pkg::MODE_WRITE &&
                        in_item.coef_index == '0 && in_item.coef_side == dspf_pkg::SIDE_LEFT;
  assign ctrl_r.wr[0] = adv[0] && in_item.mode == dspf_pkg::MODE_WRITE &&
                        in_item.coef_index == '0 && in_item.coef_side == dspf_pkg::SIDE_RIGHT;
  assign ctrl_l.wr_value[0] = in_item.coef_value;
  assign ctrl_r.wr_value[0] = in_item.coef_value;

  for (genvar k = 1; k <= dspf_pkg::POLY_DEGREE; k++) begin : g_wr
    logic hit;
    assign hit = adv[k] && mode_r[k] == dspf_pkg::MODE_WRITE && int'(idx_r[k]) == k;
    assign ctrl_l.wr[k]       = hit && side_r[k] == dspf_pkg::SIDE_LEFT;
    assign ctrl_r.wr[k]       = hit && side_r[k] == dspf_pkg::SIDE_RIGHT;
    assign ctrl_l.wr_value[k] = value_r[k];
    assign ctrl_r.wr_value[k] = value_r[k];
  end

  dspf_lane u_lane_left (
    .clk    (clk),
    .ctrl   (ctrl_l),
    .sample (in_item.left_sample),
    .result (dist_l)
  );

  dspf_lane u_lane_right (
    .clk    (clk),
    .ctrl   (ctrl_r),
    .sample (in_item.right_sample),
    .result (dist_r)
  );

  assign merge_load = adv[dspf_pkg::NUM_STG] &&
                      mode_r[dspf_pkg::NUM_STG] == dspf_pkg::MODE_FUSE;

  dspf_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (merge_load),
    .left      (dist_l),
    .right     (dist_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_empty_entry_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[1] |-> !in_stall)
    else $error("input stalled while the first stage is empty");

  a_result_from_fuse: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(v_r[dspf_pkg::NUM_STG] && mode_r[dspf_pkg::NUM_STG] == dspf_pkg::MODE_FUSE))
    else $error("result appeared without a sample pair in the last stage");

  a_blocked_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && !adv[1]) |=> v_r[1])
    else $error("blocked first stage lost its item");

endmodule

// File: dv/tb_dual_sensor_poly_fusion_core.sv
// Testbench for dual_sensor_poly_fusion_core: directed table plus predictor-checked random items.
`timescale 1ns / 1ps

module tb_dual_sensor_poly_fusion_core;
  import dspf_pkg::*;

  localparam int N_DIR       = 31;
  localparam int N_RANDOM    = 1450;
  localparam int DRAIN       = POLY_DEGREE + 2;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    dspf_mode_t               mode;
    logic [SAMPLE_W-1:0]      left_raw;
    logic [SAMPLE_W-1:0]      right_raw;
    dspf_side_t               side;
    logic [IDX_W-1:0]         power;
    logic signed [COEF_W-1:0] coef;
    bit                       typed;
    logic signed [COEF_W-1:0] want_dist;
    dspf_src_t                want_src;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  dspf_in_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  dspf_out_t out_item;

  logic signed [COEF_W-1:0] cal_coef [2][NUM_STG];
  dspf_out_t                fused_q [$];
  int                       mismatch_count   = 0;
  int                       burst_left       = 0;
  int                       stall_phase_left = 0;
  int                       stall_style      = 0;
  int unsigned              cycle_count      = 0;

  dir_row_t dir_rows [N_DIR] = '{
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_LEFT, 3'd0, 32'sd3276800, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_LEFT, 3'd1, 32'sd0, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_LEFT, 3'd2, 32'sd0, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_LEFT, 3'd3, 32'sd0, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_LEFT, 3'd4, 32'sd0, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd0, 32'sd1966080, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd1, 32'sd0, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd2, 32'sd0, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd3, 32'sd0, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd4, 32'sd0, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_FUSE, 10'd0, 10'd0, SIDE_LEFT, 3'd0, 32'sd0, 1'b1, 32'sd1966080, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd0, 32'sd2949120, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_FUSE, 10'd0, 10'd0, SIDE_LEFT, 3'd0, 32'sd0, 1'b1, 32'sd3112960, SRC_AVG},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_LEFT, 3'd0, 32'sd4587520, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_FUSE, 10'd1023, 10'd1023, SIDE_LEFT, 3'd0, 32'sd0, 1'b1, 32'sd4587520, SRC_LEFT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_LEFT, 3'd1, S32_MAX, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_FUSE, 10'd1023, 10'd0, SIDE_LEFT, 3'd0, 32'sd0, 1'b1, S32_MAX, SRC_LEFT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_LEFT, 3'd0, 32'sd4259840, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_LEFT, 3'd1, S32_MIN, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd0, 32'sd2621440, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_FUSE, 10'd0, 10'd0, SIDE_LEFT, 3'd0, 32'sd0, 1'b1, 32'sd3440640, SRC_AVG},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd0, 32'sd2621439, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_FUSE, 10'd0, 10'd0, SIDE_LEFT, 3'd0, 32'sd0, 1'b1, 32'sd2621439, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd0, S32_MIN, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_FUSE, 10'd1023, 10'd0, SIDE_LEFT, 3'd0, 32'sd0, 1'b1, S32_MIN, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd0, S32_MAX, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd4, S32_MAX, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_FUSE, 10'd512, 10'd1023, SIDE_LEFT, 3'd0, 32'sd0, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_LEFT, 3'd5, 32'sh1234_5678, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_WRITE, 10'd0, 10'd0, SIDE_RIGHT, 3'd7, S32_MIN, 1'b0, 32'sd0, SRC_RIGHT},
    '{MODE_FUSE, 10'd1023, 10'd1023, SIDE_LEFT, 3'd0, 32'sd0, 1'b0, 32'sd0, SRC_RIGHT}
  };

  dual_sensor_poly_fusion_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #2 clk = ~clk;

  function automatic longint clamp_s32(input longint v);
    if (v > longint'(S32_MAX)) begin
      return longint'(S32_MAX);
    end
    if (v < longint'(S32_MIN)) begin
      return longint'(S32_MIN);
    end
    return v;
  endfunction

  function automatic longint lane_distance(input int side, input logic [SAMPLE_W-1:0] raw);
    longint x;
    longint pw;
    longint acc;
    int     i;
    x   = (longint'(raw) << FRAC_W) >> ADC_BITS;
    pw  = 64'sd1 << FRAC_W;
    acc = longint'(cal_coef[side][0]);
    for (i = 1; i <= POLY_DEGREE; i++) begin
      pw = (pw * x) >> FRAC_W;
      if (pw > 64'sh0_FFFF_FFFF) begin
        pw = 64'sh0_FFFF_FFFF;
      end
      acc = clamp_s32(acc + ((longint'(cal_coef[side][i]) * pw) >>> FRAC_W));
    end
    return acc;
  endfunction

  function automatic dspf_out_t fuse_prediction(input logic [SAMPLE_W-1:0] left_raw,
                                                input logic [SAMPLE_W-1:0] right_raw);
    longint    ld;
    longint    rd;
    longint    d;
    dspf_out_t res;
    ld = lane_distance(SIDE_LEFT, left_raw);
    rd = lane_distance(SIDE_RIGHT, right_raw);
    if (rd < longint'(RIGHT_NEAR_Q)) begin
      d          = rd;
      res.source = SRC_RIGHT;
    end else if (ld > longint'(LEFT_FAR_Q)) begin
      d          = ld;
      res.source = SRC_LEFT;
    end else begin
      d          = (ld + rd) >>> 1;
      res.source = SRC_AVG;
    end
    res.distance = d[COEF_W-1:0];
    return res;
  endfunction

  task automatic record_accepted(input dspf_in_t it, input bit typed, input dspf_out_t want);
    if (it.mode == MODE_WRITE) begin
      if (it.coef_index <= POLY_DEGREE) begin
        cal_coef[it.coef_side][it.coef_index] = it.coef_value;
      end
    end else begin
      fused_q.push_back(typed ? want : fuse_prediction(it.left_sample, it.right_sample));
    end
  endtask

  task automatic send_item(input dspf_in_t it, input bit typed, input dspf_out_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    record_accepted(it, typed, want);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // hold off results on a pattern that changes phase now and then
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_style      = $urandom_range(0, 2);
      stall_phase_left = $urandom_range(20, 200);
    end else begin
      stall_phase_left--;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    dspf_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fused_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result distance=%0d source=%0d",
                                  out_item.distance, out_item.source));
      end else begin
        want = fused_q.pop_front();
        if (out_item.distance !== want.distance) begin
          report_mismatch($sformatf("distance got %0d want %0d (source want %0d)",
                                    out_item.distance, want.distance, want.source));
        end
        if (out_item.source !== want.source) begin
          report_mismatch($sformatf("source got %0d want %0d (distance want %0d)",
                                    out_item.source, want.source, want.distance));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    dspf_in_t  it;
    dspf_out_t want;
    int        n;
    foreach (cal_coef[s, k]) begin
      cal_coef[s][k] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    foreach (dir_rows[k]) begin
      it              = '0;
      it.mode         = dir_rows[k].mode;
      it.left_sample  = dir_rows[k].left_raw;
      it.right_sample = dir_rows[k].right_raw;
      it.coef_side    = dir_rows[k].side;
      it.coef_index   = dir_rows[k].power;
      it.coef_value   = dir_rows[k].coef;
      want.distance   = dir_rows[k].want_dist;
      want.source     = dir_rows[k].want_src;
      send_item(it, dir_rows[k].typed, want);
    end

    for (n = 0; n < N_RANDOM; n++) begin
      it.mode = ($urandom_range(0, 9) < 6) ? MODE_FUSE : MODE_WRITE;
      case ($urandom_range(0, 7))
        0: it.left_sample = '0;
        1: it.left_sample = '1;
        default: it.left_sample = SAMPLE_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0: it.right_sample = '0;
        1: it.right_sample = '1;
        default: it.right_sample = SAMPLE_W'($urandom);
      endcase
      it.coef_side  = 1'($urandom_range(0, 1));
      it.coef_index = IDX_W'(($urandom_range(0, 9) == 0) ? $urandom_range(POLY_DEGREE + 1, 7)
                                                         : $urandom_range(0, POLY_DEGREE));
      case ($urandom_range(0, 7))
        0: it.coef_value = $urandom;
        1: it.coef_value = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
        default: begin
          if (it.coef_index == 0) begin
            it.coef_value = $urandom_range(20 * 65536, 90 * 65536);
          end else begin
            it.coef_value = int'($urandom_range(0, 60 * 65536)) - 30 * 65536;
          end
        end
      endcase
      send_item(it, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (fused_q.size() != 0) @(posedge clk);
    repeat (4 * DRAIN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
